// ----- design/prl_pkg.sv -----
// Shared constants, codes and types of the positional ring list engine.
package prl_pkg;

    // Number of entries the list can hold.
    localparam int CAPACITY = 16;

    // Widths of the fields and of the internal counters.
    localparam int MODE_W  = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int STAT_W  = 3;
    localparam int LEN_W   = 5;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Operation codes carried by the mode field.
    typedef enum logic [MODE_W-1:0] {
        M_INS_FRONT = 3'd0,
        M_INS_END   = 3'd1,
        M_INS_AT    = 3'd2,
        M_DEL_FRONT = 3'd3,
        M_DEL_END   = 3'd4,
        M_DEL_AT    = 3'd5,
        M_SEARCH    = 3'd6
    } t_mode;

    // Status codes returned with every result.
    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_RANGE    = 3'd3,
        ST_FULL     = 3'd4,
        ST_NOTFOUND = 3'd5
    } t_status;

    // Command broadcast along the row of entry cells.
    typedef struct packed {
        logic                      ins;
        logic                      del;
        logic [IDX_W-1:0]          idx;
        logic signed [VALUE_W-1:0] value;
    } t_cell_cmd;

endpackage

// ----- design/prl_if.sv -----
// Valid/ready channel interfaces for the request and result words.
interface prl_req_if;
    import prl_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;

    modport source (output valid, output mode, output value, output position, input ready);
    modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

interface prl_rsp_if;
    import prl_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STAT_W-1:0]         status;
    logic signed [VALUE_W-1:0] result_value;
    logic [POS_W-1:0]          found_position;
    logic [LEN_W-1:0]          length;

    modport source (output valid, output status, output result_value,
                    output found_position, output length, input ready);
    modport sink   (input valid, input status, input result_value,
                    input found_position, input length, output ready);
endinterface

// ----- design/prl_cell.sv -----
// One entry cell of the list: holds a value, shifts with its neighbours, compares with the key.
module prl_cell (
    input  logic                               i_clk,
    input  prl_pkg::t_cell_cmd                 i_cmd,
    input  logic [prl_pkg::IDX_W-1:0]          i_index,
    input  logic signed [prl_pkg::VALUE_W-1:0] i_left,
    input  logic signed [prl_pkg::VALUE_W-1:0] i_right,
    output logic signed [prl_pkg::VALUE_W-1:0] o_data,
    output logic                               o_match
);
    import prl_pkg::*;

    logic signed [VALUE_W-1:0] r_data;
    logic signed [VALUE_W-1:0] n_data;

    // An insert opens a gap at the target index by taking the left neighbour above it;
    // a delete closes the gap by taking the right neighbour from the target upwards.
    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (i_index > i_cmd.idx) begin
                n_data = i_left;
            end else if (i_index == i_cmd.idx) begin
                n_data = i_cmd.value;
            end
        end else if (i_cmd.del) begin
            if (i_index >= i_cmd.idx) begin
                n_data = i_right;
            end
        end
    end

    // Entry storage; its contents matter only once written.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_cmd.value);
endmodule

// ----- design/positional_ring_list_engine_core.sv -----
// Top level of the positional ring list engine: control, status decode and the cell row.
//
// Usage. Requests arrive as words on i_req (mode, value, position) and results leave as
// words on o_rsp (status, result_value, found_position, length), both valid/ready.
// A word moves at a rising edge with valid and ready high.
// Every request gives exactly one result word.
// A request accepted at one edge is held and decoded in the execute state, and its result
// is loaded into the output register at the edge that leaves that state; the execute state
// is held while an earlier result still waits in the output register. The engine works on
// one request at a time and takes no new request until the current one is executed. In the
// execute state the match compare across all cells and the first-match encode run, and
// every cell then shifts or loads in the same edge that writes the result.
// While a result waits in the output register a new request is still accepted; its
// completion waits until the receiver has taken the earlier result.
// Reset (i_rst_n low at a clock edge) empties the list and drops any pending result; the
// cell contents are left as they are and are never read before being written again.
module positional_ring_list_engine_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    prl_req_if.sink   i_req,
    prl_rsp_if.source o_rsp
);
    import prl_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                    r_state;
    t_mode                     r_mode;
    logic signed [VALUE_W-1:0] r_value;
    logic [POS_W-1:0]          r_pos;
    logic [CNT_W-1:0]          r_count;
    logic                      r_out_valid;
    t_status                   r_status;
    logic signed [VALUE_W-1:0] r_rval;
    logic [POS_W-1:0]          r_fpos;
    logic [LEN_W-1:0]          r_len;

    logic [CNT_W-1:0]          n_count;
    t_status                   n_status;
    logic signed [VALUE_W-1:0] n_rval;
    logic [POS_W-1:0]          n_fpos;

    logic                      w_exec_go;
    logic                      w_ins;
    logic                      w_del;
    logic [IDX_W-1:0]          w_idx;
    t_cell_cmd                 w_cell_cmd;
    logic signed [VALUE_W-1:0] w_data [CAPACITY];
    logic [CAPACITY-1:0]       w_match;
    logic signed [VALUE_W-1:0] w_sel_data;
    logic                      w_hit;
    logic [IDX_W-1:0]          w_first;
    logic [CMP_W-1:0]          w_pos_x;
    logic [CMP_W-1:0]          w_cnt_x;
    logic                      w_full;
    logic                      w_empty;

    // Handshake: one request at a time, the result register parts the output side.
    assign i_req.ready = (r_state == S_IDLE);
    assign w_exec_go   = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);

    // Row of entry cells, each handing its value to both neighbours.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VALUE_W-1:0] w_left;
        logic signed [VALUE_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = w_cell_cmd.value;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end
        prl_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cell_cmd),
            .i_index (IDX_W'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g]),
            .o_match (w_match[g])
        );
    end

    // First matching entry among those in use.
    always_comb begin
        w_hit   = 1'b0;
        w_first = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (w_match[k] && (CNT_W'(k) < r_count)) begin
                w_hit   = 1'b1;
                w_first = IDX_W'(k);
            end
        end
    end

    assign w_pos_x    = CMP_W'(r_pos);
    assign w_cnt_x    = CMP_W'(r_count);
    assign w_full     = (r_count >= CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_sel_data = w_data[w_idx];

    // Decode the held request into a status, a cell command and the new length.
    always_comb begin
        n_status = ST_OK;
        n_fpos   = '0;
        n_count  = r_count;
        w_ins    = 1'b0;
        w_del    = 1'b0;
        w_idx    = '0;
        case (r_mode)
            M_INS_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                end
            end
            M_INS_END: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                    w_idx = IDX_W'(r_count);
                end
            end
            M_INS_AT: begin
                if (w_pos_x == '0) begin
                    n_status = ST_BADPOS;
                end else if (w_pos_x > w_cnt_x + CMP_W'(1)) begin
                    n_status = ST_RANGE;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                    w_idx = IDX_W'(r_pos - POS_W'(1));
                end
            end
            M_DEL_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_del = 1'b1;
                end
            end
            M_DEL_END: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_del = 1'b1;
                    w_idx = IDX_W'(r_count - CNT_W'(1));
                end
            end
            M_DEL_AT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (w_pos_x == '0) begin
                    n_status = ST_BADPOS;
                end else if (w_pos_x > w_cnt_x) begin
                    n_status = ST_RANGE;
                end else begin
                    w_del = 1'b1;
                    w_idx = IDX_W'(r_pos - POS_W'(1));
                end
            end
            M_SEARCH: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (w_hit) begin
                    n_fpos = POS_W'(w_first) + POS_W'(1);
                end else begin
                    n_status = ST_NOTFOUND;
                end
            end
            default: begin
            end
        endcase
        if (w_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // The removed value is the entry at the delete index before the shift.
    assign n_rval = w_del ? w_sel_data : '0;

    // Cells move only in the cycle the result is written.
    always_comb begin
        w_cell_cmd.ins   = w_ins && w_exec_go;
        w_cell_cmd.del   = w_del && w_exec_go;
        w_cell_cmd.idx   = w_idx;
        w_cell_cmd.value = r_value;
    end

    // Control state, held request and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_exec_go) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_mode  <= t_mode'(i_req.mode);
                        r_value <= i_req.value;
                        r_pos   <= i_req.position;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_exec_go) begin
                        r_count     <= n_count;
                        r_status    <= n_status;
                        r_rval      <= n_rval;
                        r_fpos      <= n_fpos;
                        r_len       <= LEN_W'(n_count);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_status;
    assign o_rsp.result_value   = r_rval;
    assign o_rsp.found_position = r_fpos;
    assign o_rsp.length         = r_len;
endmodule

// ----- design/prl_chk.sv -----
// Port-level checker for the positional ring list engine, bound to the top level.
module prl_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [prl_pkg::STAT_W-1:0]         i_status,
    input logic signed [prl_pkg::VALUE_W-1:0] i_result_value,
    input logic [prl_pkg::POS_W-1:0]          i_found_position,
    input logic [prl_pkg::LEN_W-1:0]          i_length
);
    import prl_pkg::*;

    // A stalled result word holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_status)
            && $stable(i_result_value) && $stable(i_found_position) && $stable(i_length)))
        else $error("result word changed while stalled");

    // Requests are worked one at a time, so ready drops after an accept.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request accepted while another is in progress");

    // The reported length never exceeds the capacity.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (LEN_W'(CAPACITY) >= i_length))
        else $error("length above capacity");

    // A found position only comes with an ok status, never together with a removed value.
    a_side_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_found_position != '0)) |->
            ((i_status == ST_OK) && (i_result_value == '0)))
        else $error("found position with wrong status or value");

    // No result is pending straight after reset.
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind positional_ring_list_engine_core prl_chk u_prl_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_req.valid),
    .i_in_ready       (i_req.ready),
    .i_out_valid      (o_rsp.valid),
    .i_out_ready      (o_rsp.ready),
    .i_status         (o_rsp.status),
    .i_result_value   (o_rsp.result_value),
    .i_found_position (o_rsp.found_position),
    .i_length         (o_rsp.length)
);
